// ===== src/cnlb_pkg.sv =====
// ----------------------------------------------------------------------------
// Card number check package
// Shared widths, sequencer states, converter control and brand decode.
// ----------------------------------------------------------------------------
package cnlb_pkg;

  localparam int VALUE_W    = 54;  // binary card number width
  localparam int NUM_DIGITS = 17;  // decimal digits a 54-bit value can need
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int MAX_DIGITS = 16;  // longest number that may carry a brand
  localparam int CNT_W      = 6;   // covers both the bit and the digit passes

  localparam logic [1:0] BRAND_INVALID    = 2'd0;
  localparam logic [1:0] BRAND_AMEX       = 2'd1;
  localparam logic [1:0] BRAND_MASTERCARD = 2'd2;
  localparam logic [1:0] BRAND_VISA       = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;      // take a new binary value, clear the digits
    logic step_bin;  // one shift-add step of the conversion
    logic step_dig;  // drop the lowest decimal digit
  } conv_ctrl_t;

  function automatic logic [1:0] classify(input logic [4:0] count,
                                          input logic [3:0] lead,
                                          input logic [3:0] nxt);
    logic [1:0] b;
    b = BRAND_INVALID;
    if (count == 5'd15 && lead == 4'd3 && (nxt == 4'd4 || nxt == 4'd7))
      b = BRAND_AMEX;
    else if (count == 5'd16 && lead == 4'd5 && nxt >= 4'd1 && nxt <= 4'd5)
      b = BRAND_MASTERCARD;
    else if ((count == 5'd13 || count == 5'd16) && lead == 4'd4)
      b = BRAND_VISA;
    return b;
  endfunction

endpackage

// ===== src/cnlb_conv.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal converter
// Shift-add conversion one bit a cycle, then hands out digits lowest first.
// ----------------------------------------------------------------------------
module cnlb_conv (
  input  logic                      clk,
  input  cnlb_pkg::conv_ctrl_t      ctrl,
  input  logic [cnlb_pkg::VALUE_W-1:0] load_value,
  output logic [3:0]                digit
);
  import cnlb_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3
                                                   : bcd[4*k +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= load_value;
      bcd <= '0;
    end else if (ctrl.step_bin) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
    end else if (ctrl.step_dig) begin
      bcd <= {4'd0, bcd[BCD_W-1:4]};
    end
  end

  assign digit = bcd[3:0];

endmodule

// ===== src/card_number_luhn_brand_check.sv =====
// ----------------------------------------------------------------------------
// Card number Luhn and brand check
// Takes one binary card number a word and returns its digit count, Luhn
// result and brand. The converter loads at the accepting edge, then runs
// 54 steps of the serial binary-to-decimal conversion (one input bit a cycle)
// and 17 steps of the digit scan (one decimal digit a cycle). The final state
// then loads the output register, and the block returns to idle; no new word
// is taken before the last one is through. The next word is taken once the
// result sits in the output register. A result left waiting there holds the
// block in its last step until it is taken. No word is taken while reset is
// high.
// ----------------------------------------------------------------------------
module card_number_luhn_brand_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [53:0] card_value, [55:54] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [1:0] brand, [2] sum_ok, [7:3] digit_count
);
  import cnlb_pkg::*;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_DIGITS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  conv_ctrl_t       ctrl;
  logic             fin_load;
  logic [3:0]       digit;

  logic [3:0] sum;
  logic [4:0] count;
  logic [3:0] lead_digit;
  logic [3:0] next_digit;
  logic [3:0] prev_digit;

  logic [1:0] brand;
  logic       sum_ok;
  logic [4:0] digit_count;

  logic [4:0] dbl;
  logic [4:0] term;
  logic [4:0] acc;
  logic       in_fire;

  assign in_fire = s_tvalid && s_tready;

  cnlb_conv u_conv (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_value (s_tdata[VALUE_W-1:0]),
    .digit      (digit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_CONV;
      S_CONV: if (cnt == CONV_LAST) state_next = S_SCAN;
      S_SCAN: if (cnt == SCAN_LAST) state_next = S_FIN;
      S_FIN:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    ctrl          = '0;
    fin_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready  = !rst;
        ctrl.load = s_tvalid && !rst;
      end
      S_CONV:  ctrl.step_bin = 1'b1;
      S_SCAN:  ctrl.step_dig = 1'b1;
      S_FIN:   fin_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else if (state == S_CONV || state == S_SCAN) cnt <= cnt + 1'b1;
    end
  end

  // Luhn term: every second digit from the right, starting with the second, is doubled, digit-summed
  always_comb begin
    dbl  = {digit, 1'b0};
    term = {1'b0, digit};
    if (cnt[0]) term = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
    acc  = {1'b0, sum} + term;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sum        <= '0;
      count      <= '0;
      lead_digit <= '0;
      next_digit <= '0;
      prev_digit <= '0;
    end else if (ctrl.step_dig) begin
      sum        <= (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
      prev_digit <= digit;
      // the highest non-zero digit seen so far leads the number
      if (digit != 4'd0) begin
        count      <= cnt[4:0] + 5'd1;
        lead_digit <= digit;
        next_digit <= prev_digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      sum_ok      <= (sum == 4'd0);
      digit_count <= count;
      if (sum == 4'd0 && count != 5'd0 && count <= 5'(MAX_DIGITS))
        brand <= classify(count, lead_digit, next_digit);
      else
        brand <= BRAND_INVALID;
    end
  end

  assign m_tdata = {digit_count, sum_ok, brand};

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV || state == S_SCAN) |-> !s_tready)
    else $error("input taken while an item is in progress");

  a_brand_needs_sum: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != BRAND_INVALID) |-> m_tdata[2])
    else $error("brand given without a good Luhn sum");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:3] <= 5'(NUM_DIGITS)))
    else $error("digit count out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CONV && cnt == '0))
    else $error("accepted word did not start a conversion");
`endif

endmodule
